### hdl/swm_pkg.sv
// Package for the sliding window maximum block: sizes, register codes,
// slot arithmetic and the command and status structs between control and datapath.
// No dependencies.
`default_nettype none

package swm_pkg;

  // Store depth and derived widths.
  localparam int WINDOW_MAX = 64;
  localparam int SLOT_W     = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

  // Field and register widths.
  localparam int SAMPLE_W   = 32;
  localparam int WLEN_W     = 7;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register index carried on address bit 2.
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(3);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // Store the item and set up the scan.
    logic issue;   // Present the next read address to the store.
    logic cmp;     // Read data is valid this cycle: fold it into the maximum.
    logic load;    // Copy the maximum into the output register.
  } swm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic produce;  // The item being offered completes a window.
    logic rd_done;  // No reads are left to issue.
  } swm_sts_t;

  // Next slot of the ring store, with wrap.
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    if (s == SLOT_W'(WINDOW_MAX - 1)) begin
      return '0;
    end
    return s + SLOT_W'(1);
  endfunction

  // Previous slot of the ring store, with wrap.
  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    if (s == '0) begin
      return SLOT_W'(WINDOW_MAX - 1);
    end
    return s - SLOT_W'(1);
  endfunction

  // Window length clamped to the range 1 to WINDOW_MAX.
  function automatic logic [CNT_W-1:0] eff_window(input logic [WLEN_W-1:0] wl);
    if (wl == '0) begin
      return CNT_W'(1);
    end
    if (32'(wl) > 32'(WINDOW_MAX)) begin
      return CNT_W'(WINDOW_MAX);
    end
    return CNT_W'(wl);
  endfunction

endpackage

`default_nettype wire

### hdl/sliding_window_maximum.sv
// Each accepted item is written to the store; an item that completes a window
// then starts a scan of the k-1 stored samples before it through the single
// store read port, where k is the clamped window length, and its maximum is
// loaded once any previous result is no longer held by out_stall. Input is
// stalled from the scan until that load; other items need no scan.
// Reset (synchronous, rst_n low) clears the window length to 3, the slot and
// fill counters and the control state; store contents are not cleared.
`default_nettype none

module sliding_window_maximum
  import swm_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Input items.
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [SAMPLE_W-1:0]   in_sample,
  input  wire logic                         in_start_new,
  // Result items.
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [SAMPLE_W-1:0]        out_window_max,
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [APB_ADDR_W-1:0]        paddr,
  input  wire logic [APB_DATA_W-1:0]        pwdata,
  output logic      [APB_DATA_W-1:0]        prdata,
  output logic                              pready
);

  swm_cmd_t          cmd;
  swm_sts_t          sts;
  logic              cfg_we;
  logic [WLEN_W-1:0] win_len;

  // Register decode: only the window length register exists.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);
  assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? APB_DATA_W'(win_len) : '0;

  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  swm_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_sample      (in_sample),
    .in_start_new   (in_start_new),
    .cfg_we         (cfg_we),
    .cfg_wdata      (pwdata[WLEN_W-1:0]),
    .win_len        (win_len),
    .out_window_max (out_window_max)
  );

endmodule

`default_nettype wire

### hdl/swm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/swm_datapath.sv
// Datapath of the sliding window maximum: window length register, ring store,
// slot and fill counters, read pointer and the running maximum.
// Depends on swm_pkg and swm_ram.
`default_nettype none

module swm_datapath
  import swm_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire swm_cmd_t                   cmd,
  output swm_sts_t                        sts,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic                       in_start_new,
  input  wire logic                       cfg_we,
  input  wire logic [WLEN_W-1:0]          cfg_wdata,
  output logic [WLEN_W-1:0]               win_len,
  output logic signed [SAMPLE_W-1:0]      out_window_max
);

  logic [WLEN_W-1:0]          win_len_r;
  logic [SLOT_W-1:0]          next_slot_r;
  logic [CNT_W-1:0]           filled_r;
  logic [CNT_W-1:0]           filled_nxt;
  logic [CNT_W-1:0]           k;
  logic [SLOT_W-1:0]          rd_ptr_r;
  logic [CNT_W-1:0]           rd_left_r;
  logic signed [SAMPLE_W-1:0] best_r;
  logic signed [SAMPLE_W-1:0] out_data_r;
  logic [SAMPLE_W-1:0]        rdata;

  assign k       = eff_window(win_len_r);
  assign win_len = win_len_r;

  // Fill count after the offered item: a start flag restarts it at one.
  always_comb begin
    if (in_start_new) begin
      filled_nxt = CNT_W'(1);
    end else if (filled_r == CNT_W'(WINDOW_MAX)) begin
      filled_nxt = filled_r;
    end else begin
      filled_nxt = filled_r + CNT_W'(1);
    end
  end

  assign sts.produce = (filled_nxt >= k);
  assign sts.rd_done = (rd_left_r == '0);

  // Control state: configuration and ring position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= WLEN_RESET;
      next_slot_r <= '0;
      filled_r    <= '0;
    end else begin
      if (cfg_we) begin
        win_len_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        next_slot_r <= slot_inc(next_slot_r);
        filled_r    <= filled_nxt;
      end
    end
  end

  // Scan pointer, remaining reads and the running maximum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_left_r <= '0;
    end else if (cmd.accept) begin
      rd_left_r <= k - CNT_W'(1);
    end else if (cmd.issue) begin
      rd_left_r <= rd_left_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_ptr_r <= slot_dec(next_slot_r);
      best_r   <= in_sample;
    end else begin
      if (cmd.issue) begin
        rd_ptr_r <= slot_dec(rd_ptr_r);
      end
      if (cmd.cmp && ($signed(rdata) > best_r)) begin
        best_r <= $signed(rdata);
      end
    end
    if (cmd.load) begin
      out_data_r <= best_r;
    end
  end

  assign out_window_max = out_data_r;

  // Ring store of recent samples.
  swm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_MAX)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (next_slot_r),
    .wdata (in_sample),
    .raddr (rd_ptr_r),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

### hdl/swm_ctrl.sv
// Controller of the sliding window maximum: accepts items, sequences the
// store scan and owns the output valid flag.
// Depends on swm_pkg.
`default_nettype none

module swm_ctrl
  import swm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire swm_sts_t sts,
  output swm_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   rd_pend_r, rd_pend_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state, commands and output flag.
  always_comb begin
    state_nxt     = state_r;
    rd_pend_nxt   = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.produce) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue   = !sts.rd_done;
        cmd.cmp     = rd_pend_r;
        rd_pend_nxt = cmd.issue;
        if (sts.rd_done && !rd_pend_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### hdl/swm_checker.sv
// Port-level checks for the sliding window maximum, bound to the top level.
// Depends on swm_pkg and sliding_window_maximum.
`default_nettype none

module swm_checker
  import swm_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic signed [SAMPLE_W-1:0] out_window_max,
  input wire logic                       psel,
  input wire logic                       penable,
  input wire logic                       pwrite,
  input wire logic [APB_ADDR_W-1:0]      paddr,
  input wire logic [APB_DATA_W-1:0]      pwdata,
  input wire logic [APB_DATA_W-1:0]      prdata,
  input wire logic                       pready
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_window_max))
    else $error("result changed while stalled");

  // A result never appears in the cycle right after an item is taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too soon after an item");

  // A window length write reads back in the next cycle.
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LENGTH)
    |=> (paddr[2] != REG_WINDOW_LENGTH) ||
        (prdata[WLEN_W-1:0] == $past(pwdata[WLEN_W-1:0])))
    else $error("window length readback mismatch");

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (.*);

`default_nettype wire

### sim/sliding_window_maximum_test.sv
// Self-checking testbench for the sliding window maximum block.
// Drives directed and random samples, checks each maximum against a local predictor.
// Depends on swm_pkg and sliding_window_maximum.
`timescale 1ns / 1ps

module sliding_window_maximum_test;
  import swm_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_PAUSE = WINDOW_MAX + 16;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 155;
  localparam int PLAN_ROWS   = 23;

  localparam logic [SAMPLE_W-1:0] SMIN = 32'h8000_0000;
  localparam logic [SAMPLE_W-1:0] SMAX = 32'h7FFF_FFFF;

  // Register addresses: the window length and an index the block ignores.
  localparam logic [APB_ADDR_W-1:0] ADDR_WLEN   = {REG_WINDOW_LENGTH, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = {~REG_WINDOW_LENGTH, 2'b00};

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic                  start;
    logic                  pinned;
    logic [APB_ADDR_W-1:0] addr;
    logic [31:0]           word;   // Sample for an item, write data for a register.
    logic [SAMPLE_W-1:0]   pin;    // Expected maximum where pinned.
  } plan_row_t;

  // Directed stimulus. The window length is 3 after reset.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_ITEM, 1'b0, 1'b0, ADDR_WLEN,   SMIN,          32'd0},
    '{ROW_ITEM, 1'b0, 1'b0, ADDR_WLEN,   SMAX,          32'd0},
    '{ROW_ITEM, 1'b0, 1'b1, ADDR_WLEN,   32'd0,         SMAX},
    '{ROW_ITEM, 1'b0, 1'b1, ADDR_WLEN,   32'hFFFF_FFFF, SMAX},
    '{ROW_ITEM, 1'b0, 1'b0, ADDR_WLEN,   32'hFFFF_FFFE, 32'd0},
    '{ROW_ITEM, 1'b1, 1'b0, ADDR_WLEN,   32'd7,         32'd0},
    '{ROW_ITEM, 1'b0, 1'b0, ADDR_WLEN,   32'd3,         32'd0},
    '{ROW_ITEM, 1'b0, 1'b1, ADDR_WLEN,   32'd5,         32'd7},
    '{ROW_REG,  1'b0, 1'b0, ADDR_WLEN,   32'd0,         32'd0},
    '{ROW_ITEM, 1'b0, 1'b1, ADDR_WLEN,   SMIN,          SMIN},
    '{ROW_ITEM, 1'b1, 1'b1, ADDR_WLEN,   32'hFFFF_FFFB, 32'hFFFF_FFFB},
    '{ROW_REG,  1'b0, 1'b0, ADDR_UNUSED, 32'd1,         32'd0},
    '{ROW_ITEM, 1'b0, 1'b1, ADDR_WLEN,   32'd4,         32'd4},
    '{ROW_REG,  1'b0, 1'b0, ADDR_WLEN,   32'h0000_0085, 32'd0},
    '{ROW_ITEM, 1'b0, 1'b0, ADDR_WLEN,   32'd9,         32'd0},
    '{ROW_ITEM, 1'b0, 1'b0, ADDR_WLEN,   32'd2,         32'd0},
    '{ROW_ITEM, 1'b0, 1'b0, ADDR_WLEN,   32'd1,         32'd0},
    '{ROW_REG,  1'b0, 1'b0, ADDR_WLEN,   32'd2,         32'd0},
    '{ROW_ITEM, 1'b0, 1'b0, ADDR_WLEN,   32'd8,         32'd0},
    '{ROW_ITEM, 1'b0, 1'b0, ADDR_WLEN,   32'hFFFF_FFFD, 32'd0},
    '{ROW_REG,  1'b0, 1'b0, ADDR_WLEN,   32'hFFFF_FFFF, 32'd0},
    '{ROW_ITEM, 1'b1, 1'b0, ADDR_WLEN,   SMAX,          32'd0},
    '{ROW_ITEM, 1'b0, 1'b0, ADDR_WLEN,   32'd0,         32'd0}
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_W-1:0]    in_sample = '0;
  logic                          in_start_new = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0]    out_window_max;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]         paddr = '0;
  logic [APB_DATA_W-1:0]         pwdata = '0;
  logic [APB_DATA_W-1:0]         prdata;
  logic                          pready;

  // Predictor state.
  logic signed [SAMPLE_W-1:0]    ring [WINDOW_MAX];
  int                            head;
  int                            fill;
  logic [WLEN_W-1:0]             wlen_reg;

  logic signed [SAMPLE_W-1:0]    pending_max [$];
  logic signed [SAMPLE_W-1:0]    want;
  bit                            idle_on;
  int                            errors;
  int                            items_sent;
  int                            maxima_checked;
  int                            reg_writes;
  int                            quiet;

  sliding_window_maximum dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_start_new  (in_start_new),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_window_max(out_window_max),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Store one sample and report whether it completes a window, and its maximum.
  function automatic bit window_step(input logic signed [SAMPLE_W-1:0] s, input logic st,
                                     output logic signed [SAMPLE_W-1:0] mx);
    int k;
    int p;
    k = (wlen_reg == '0) ? 1 : ((wlen_reg > WINDOW_MAX) ? WINDOW_MAX : int'(wlen_reg));
    if (st) begin
      fill = 0;
    end
    ring[head] = s;
    head = (head + 1) % WINDOW_MAX;
    if (fill < WINDOW_MAX) begin
      fill++;
    end
    mx = s;
    if (fill < k) begin
      return 1'b0;
    end
    // Walk back from the newest sample over the whole window.
    p = head;
    for (int i = 0; i < k; i++) begin
      p = (p + WINDOW_MAX - 1) % WINDOW_MAX;
      if (ring[p] > mx) begin
        mx = ring[p];
      end
    end
    return 1'b1;
  endfunction

  // Offer one item after a random gap (none when idling is off) and record its expected maximum once accepted.
  task automatic send_item(input logic signed [SAMPLE_W-1:0] s, input logic st,
                           input logic pinned, input logic signed [SAMPLE_W-1:0] pin);
    int gap;
    bit has_max;
    logic signed [SAMPLE_W-1:0] mx;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_start_new <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    has_max = window_step(s, st, mx);
    if (has_max || pinned) begin
      pending_max.push_back(pinned ? pin : mx);
    end
  endtask

  // Let the block drain before a register write or the end of the run.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_max.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // Register write with setup and access phases, then the bus returns to idle.
  task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[2] == REG_WINDOW_LENGTH) begin
      wlen_reg = data[WLEN_W-1:0];
    end
    reg_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: hold stall for a random number of cycles before each item.
  initial begin : result_sink
    int hold;
    forever begin
      hold = idle_on ? $urandom_range(0, 11) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expected maximum.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      maxima_checked++;
      if (pending_max.size() == 0) begin
        $display("%0t: unexpected result, expected none, got window_max=%0d",
                 $time, out_window_max);
        errors++;
      end else begin
        want = pending_max.pop_front();
        if (out_window_max !== want) begin
          $display("%0t: window_max mismatch, expected %0d, got %0d",
                   $time, want, out_window_max);
          errors++;
        end
      end
    end
  end

  // End the run when nothing moves for too long.
  initial begin : watchdog
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("sliding_window_maximum regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] w;
    logic signed [SAMPLE_W-1:0] s;
    logic st;
    int ramp;
    errors = 0;
    items_sent = 0;
    maxima_checked = 0;
    reg_writes = 0;
    idle_on = 1'b1;
    ramp = 0;
    head = 0;
    fill = 0;
    wlen_reg = WLEN_RESET;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    foreach (PLAN[r]) begin
      if (PLAN[r].kind == ROW_REG) begin
        settle();
        reg_write(PLAN[r].addr, PLAN[r].word);
      end else begin
        send_item(PLAN[r].word, PLAN[r].start, PLAN[r].pinned, PLAN[r].pin);
      end
    end

    // Random phases, each under its own window length; some run without idling.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      idle_on = (p % 3 != 2);
      case (p)
        0: w = 32'd1;
        1: w = WINDOW_MAX;
        2: w = 32'd0;
        3: w = 32'd127;
        4: w = 32'd2;
        5: w = WINDOW_MAX + 1;
        default: w = ($urandom & 32'hFFFF_FF80) | $urandom_range(1, 40);
      endcase
      if ($urandom_range(0, 1) == 0) begin
        reg_write(ADDR_UNUSED, $urandom);
      end
      reg_write(ADDR_WLEN, w);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Mostly long sequences, with an occasional restart.
        st = (n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 149) == 0);
        case ($urandom_range(0, 9)) inside
          [0:3]: s = $urandom;
          [4:6]: s = $urandom_range(0, 16) - 8;
          7: s = $urandom_range(0, 1) ? SMAX : SMIN;
          8: begin
            ramp = ramp + $urandom_range(1, 3);
            s = ramp;
          end
          default: begin
            // Falling step: each such sample is below the previous ramp sample.
            ramp = ramp - $urandom_range(1, 3);
            s = ramp;
          end
        endcase
        send_item(s, st, 1'b0, '0);
      end
    end

    settle();
    $display("Ran %0d samples through %0d register writes; %0d window maxima checked.",
             items_sent, reg_writes, maxima_checked);
    if (errors == 0) begin
      $display("sliding_window_maximum regression: pass");
    end else begin
      $display("sliding_window_maximum regression: fail");
    end
    $finish;
  end

endmodule
